@@ rtl/rfft_pkg.sv @@
package rfft_pkg;

  localparam int SAMPLE_W = 16;
  localparam int WORK_W   = 24;
  localparam int BIN_W    = 7;

  localparam real PI = 3.14159265358979323846;

  localparam logic signed [WORK_W-1:0] SUM_MAX = 24'sh7FFFFF;
  localparam logic signed [WORK_W-1:0] SUM_MIN = -24'sh800000;

  localparam logic REQ_PUSH = 1'b0;
  localparam logic REQ_READ = 1'b1;

  typedef struct packed {
    logic                       req_type;
    logic signed [SAMPLE_W-1:0] sample;
    logic [BIN_W-1:0]           bin_index;
  } item_t;

  typedef enum logic [3:0] {
    ST_IDLE,
    ST_LD_RD,
    ST_LD_WR,
    ST_BF_RDO,
    ST_BF_RDE,
    ST_M0,
    ST_M1,
    ST_M2,
    ST_M3,
    ST_M4,
    ST_WE,
    ST_WO,
    ST_RD_OUT
  } eng_state_t;

  function automatic logic signed [WORK_W-1:0] sat_work(input logic signed [WORK_W+2:0] v);
    logic signed [WORK_W-1:0] r;
    if (v > $signed({{3{SUM_MAX[WORK_W-1]}}, SUM_MAX})) begin
      r = SUM_MAX;
    end else if (v < $signed({{3{SUM_MIN[WORK_W-1]}}, SUM_MIN})) begin
      r = SUM_MIN;
    end else begin
      r = v[WORK_W-1:0];
    end
    return r;
  endfunction

endpackage

@@ rtl/rfft_ram.sv @@
module rfft_ram #(
  parameter int WIDTH = 8,
  parameter int DEPTH = 16
) (
  input  logic                     clk,
  input  logic                     we,
  input  logic [$clog2(DEPTH)-1:0] waddr,
  input  logic [WIDTH-1:0]         wdata,
  input  logic                     re,
  input  logic [$clog2(DEPTH)-1:0] raddr,
  output logic [WIDTH-1:0]         rdata
);

  logic [WIDTH-1:0] mem [DEPTH];

  always_ff @(posedge clk) begin
    if (we) begin
      mem[waddr] <= wdata;
    end
    if (re) begin
      rdata <= mem[raddr];
    end
  end

endmodule

@@ rtl/rfft_front.sv @@
module rfft_front
  import rfft_pkg::*;
(
  input  logic  clk,
  input  logic  rst,
  input  logic  in_valid,
  output logic  in_ready,
  input  item_t in_item,
  output logic  q_valid,
  input  logic  q_take,
  output item_t q_item
);

  item_t      slot [2];
  logic       wptr;
  logic       rptr;
  logic [1:0] count;
  logic       push;
  logic       pop;

  assign in_ready = (count != 2'd2);
  assign q_valid  = (count != 2'd0);
  assign q_item   = slot[rptr];
  assign push     = in_valid && in_ready;
  assign pop      = q_valid && q_take;

  always_ff @(posedge clk) begin
    if (push) begin
      slot[wptr] <= in_item;
    end
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      wptr  <= 1'b0;
      rptr  <= 1'b0;
      count <= 2'd0;
    end else begin
      if (push) begin
        wptr <= ~wptr;
      end
      if (pop) begin
        rptr <= ~rptr;
      end
      case ({push, pop})
        2'b10:   count <= count + 2'd1;
        2'b01:   count <= count - 2'd1;
        default: count <= count;
      endcase
    end
  end

endmodule

@@ rtl/rfft_engine.sv @@
module rfft_engine
  import rfft_pkg::*;
#(
  parameter int FRAME_LENGTH = 128,
  parameter int TWIDDLE_BITS = 16
) (
  input  logic                     clk,
  input  logic                     rst,
  input  logic                     q_valid,
  output logic                     q_take,
  input  item_t                    q_item,
  output logic                     out_valid,
  input  logic                     out_ready,
  output logic [BIN_W-1:0]         bin_number,
  output logic signed [WORK_W-1:0] real_part,
  output logic signed [WORK_W-1:0] imag_part,
  output logic                     spectrum_valid
);

  localparam int LOG  = $clog2(FRAME_LENGTH);
  localparam int TAW  = (LOG > 1) ? LOG - 1 : 1;
  localparam int STW  = $clog2(LOG + 1);
  localparam int TB   = TWIDDLE_BITS;
  localparam int PW   = TB + WORK_W;
  localparam int RW   = WORK_W + 2;
  localparam int TOP  = (1 << (TB - 1)) - 1;
  localparam real SCALE = real'(1 << (TB - 1));

  // twiddle table, cos - i*sin, folded about a quarter turn
  logic signed [TB-1:0] tw_re [FRAME_LENGTH/2];
  logic signed [TB-1:0] tw_im [FRAME_LENGTH/2];

  for (genvar k = 0; k < FRAME_LENGTH / 2; k++) begin : g_tw
    localparam bit  SECOND = (4 * k) > FRAME_LENGTH;
    localparam int  M      = SECOND ? (FRAME_LENGTH / 2 - k) : k;
    localparam real ANG    = 2.0 * PI * M / FRAME_LENGTH;
    localparam int  CV     = $rtoi($cos(ANG) * SCALE + 0.5);
    localparam int  SV     = $rtoi($sin(ANG) * SCALE + 0.5);
    localparam int  CF     = SECOND ? -CV : ((CV > TOP) ? TOP : CV);
    localparam int  SF     = -SV;
    assign tw_re[k] = TB'(CF);
    assign tw_im[k] = TB'(SF);
  end

  eng_state_t state, state_next;

  logic [LOG-1:0] fill_count;
  logic           have_spectrum;
  logic [LOG-1:0] cnt;
  logic [STW-1:0] stage;
  logic [BIN_W-1:0] rd_bin;

  logic signed [TB-1:0]     wr, wi;
  logic signed [WORK_W-1:0] o_re, o_im, e_re, e_im;
  logic signed [PW-1:0]     prod;
  logic signed [RW-1:0]     tr, ti;

  // sample store port
  logic                       s_we, s_re;
  logic [LOG-1:0]             s_waddr, s_raddr;
  logic [SAMPLE_W-1:0]        s_rdata;

  // work store port, {real, imag}
  logic                       w_we, w_re;
  logic [LOG-1:0]             w_waddr, w_raddr;
  logic [2*WORK_W-1:0]        w_wdata, w_rdata;

  rfft_ram #(.WIDTH(SAMPLE_W), .DEPTH(FRAME_LENGTH)) u_samples (
    .clk   (clk),
    .we    (s_we),
    .waddr (s_waddr),
    .wdata (q_item.sample),
    .re    (s_re),
    .raddr (s_raddr),
    .rdata (s_rdata)
  );

  rfft_ram #(.WIDTH(2*WORK_W), .DEPTH(FRAME_LENGTH)) u_work (
    .clk   (clk),
    .we    (w_we),
    .waddr (w_waddr),
    .wdata (w_wdata),
    .re    (w_re),
    .raddr (w_raddr),
    .rdata (w_rdata)
  );

  // butterfly addressing
  logic [LOG-1:0] mask, jj, e_addr, o_addr, t_full, rev_addr;
  logic [TAW-1:0] t_idx;
  logic [LOG+BIN_W-1:0] bin_wide;
  logic [LOG-1:0] rd_idx;

  always_comb begin
    mask     = (LOG'(1) << stage) - LOG'(1);
    jj       = cnt & mask;
    e_addr   = ((cnt & ~mask) << 1) | jj;
    o_addr   = e_addr | (LOG'(1) << stage);
    t_full   = jj << (STW'(LOG - 1) - stage);
    t_idx    = t_full[TAW-1:0];
    bin_wide = {{LOG{1'b0}}, q_item.bin_index};
    rd_idx   = bin_wide[LOG-1:0];
    for (int b = 0; b < LOG; b++) begin
      rev_addr[LOG-1-b] = cnt[b];
    end
  end

  // shared multiplier and rounding
  logic signed [TB-1:0]     mul_a;
  logic signed [WORK_W-1:0] mul_b;
  logic signed [PW:0]       rsum, rsh;
  logic signed [RW-1:0]     rnd;

  always_comb begin
    case (state)
      ST_M0:   begin mul_a = wr; mul_b = o_re; end
      ST_M1:   begin mul_a = wi; mul_b = o_im; end
      ST_M2:   begin mul_a = wr; mul_b = o_im; end
      default: begin mul_a = wi; mul_b = o_re; end
    endcase
    rsum = $signed({prod[PW-1], prod})
         + $signed({{(PW-TB+2){1'b0}}, 1'b1, {(TB-2){1'b0}}});
    rsh  = rsum >>> (TB - 1);
    rnd  = rsh[RW-1:0];
  end

  logic signed [WORK_W+2:0] sum_re, sum_im, dif_re, dif_im;

  always_comb begin
    sum_re = {{3{e_re[WORK_W-1]}}, e_re} + {tr[RW-1], tr};
    sum_im = {{3{e_im[WORK_W-1]}}, e_im} + {ti[RW-1], ti};
    dif_re = {{3{e_re[WORK_W-1]}}, e_re} - {tr[RW-1], tr};
    dif_im = {{3{e_im[WORK_W-1]}}, e_im} - {ti[RW-1], ti};
  end

  logic out_free;
  assign out_free = !out_valid || out_ready;

  always_comb begin
    state_next = state;
    q_take     = 1'b0;
    s_we       = 1'b0;
    s_waddr    = fill_count;
    s_re       = 1'b0;
    s_raddr    = cnt;
    w_we       = 1'b0;
    w_waddr    = e_addr;
    w_wdata    = {sat_work(sum_re), sat_work(sum_im)};
    w_re       = 1'b0;
    w_raddr    = o_addr;
    case (state)
      ST_IDLE: begin
        if (q_valid) begin
          q_take = 1'b1;
          if (q_item.req_type == REQ_PUSH) begin
            s_we = 1'b1;
            if (fill_count == LOG'(FRAME_LENGTH - 1)) begin
              state_next = ST_LD_RD;
            end
          end else begin
            w_re       = 1'b1;
            w_raddr    = rd_idx;
            state_next = ST_RD_OUT;
          end
        end
      end
      ST_LD_RD: begin
        s_re       = 1'b1;
        state_next = ST_LD_WR;
      end
      ST_LD_WR: begin
        w_we    = 1'b1;
        w_waddr = rev_addr;
        w_wdata = {{(WORK_W-SAMPLE_W){s_rdata[SAMPLE_W-1]}}, s_rdata, {WORK_W{1'b0}}};
        state_next = (cnt == LOG'(FRAME_LENGTH - 1)) ? ST_BF_RDO : ST_LD_RD;
      end
      ST_BF_RDO: begin
        w_re       = 1'b1;
        state_next = ST_BF_RDE;
      end
      ST_BF_RDE: begin
        w_re       = 1'b1;
        w_raddr    = e_addr;
        state_next = ST_M0;
      end
      ST_M0: state_next = ST_M1;
      ST_M1: state_next = ST_M2;
      ST_M2: state_next = ST_M3;
      ST_M3: state_next = ST_M4;
      ST_M4: state_next = ST_WE;
      ST_WE: begin
        w_we       = 1'b1;
        state_next = ST_WO;
      end
      ST_WO: begin
        w_we    = 1'b1;
        w_waddr = o_addr;
        w_wdata = {sat_work(dif_re), sat_work(dif_im)};
        if (cnt == LOG'(FRAME_LENGTH / 2 - 1) && stage == STW'(LOG - 1)) begin
          state_next = ST_IDLE;
        end else begin
          state_next = ST_BF_RDO;
        end
      end
      ST_RD_OUT: begin
        if (out_free) begin
          state_next = ST_IDLE;
        end
      end
      default: state_next = ST_IDLE;
    endcase
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      state         <= ST_IDLE;
      fill_count    <= '0;
      have_spectrum <= 1'b0;
      cnt           <= '0;
      stage         <= '0;
      out_valid     <= 1'b0;
    end else begin
      state <= state_next;
      if (state == ST_RD_OUT && out_free) begin
        out_valid <= 1'b1;
      end else if (out_valid && out_ready) begin
        out_valid <= 1'b0;
      end
      case (state)
        ST_IDLE: begin
          if (q_valid && q_item.req_type == REQ_PUSH) begin
            fill_count <= fill_count + LOG'(1);
            cnt        <= '0;
          end
        end
        ST_LD_WR: begin
          if (cnt == LOG'(FRAME_LENGTH - 1)) begin
            cnt   <= '0;
            stage <= '0;
          end else begin
            cnt <= cnt + LOG'(1);
          end
        end
        ST_WO: begin
          // advance butterfly, then stage
          if (cnt == LOG'(FRAME_LENGTH / 2 - 1)) begin
            cnt <= '0;
            if (stage == STW'(LOG - 1)) begin
              have_spectrum <= 1'b1;
            end else begin
              stage <= stage + STW'(1);
            end
          end else begin
            cnt <= cnt + LOG'(1);
          end
        end
        default: ;
      endcase
    end
  end

  always_ff @(posedge clk) begin
    case (state)
      ST_IDLE: begin
        // hold the bin until the result register is free
        if (q_valid && q_item.req_type == REQ_READ) begin
          rd_bin <= bin_wide[BIN_W-1:0] & BIN_W'({LOG+BIN_W{1'b0}} | rd_idx);
        end
      end
      ST_BF_RDO: begin
        wr <= tw_re[t_idx];
        wi <= tw_im[t_idx];
      end
      ST_BF_RDE: begin
        o_re <= w_rdata[2*WORK_W-1:WORK_W];
        o_im <= w_rdata[WORK_W-1:0];
      end
      ST_M0: begin
        e_re <= w_rdata[2*WORK_W-1:WORK_W];
        e_im <= w_rdata[WORK_W-1:0];
        prod <= mul_a * mul_b;
      end
      ST_M1: begin
        tr   <= rnd;
        prod <= mul_a * mul_b;
      end
      ST_M2: begin
        tr   <= tr - rnd;
        prod <= mul_a * mul_b;
      end
      ST_M3: begin
        ti   <= rnd;
        prod <= mul_a * mul_b;
      end
      ST_M4: begin
        ti <= ti + rnd;
      end
      ST_RD_OUT: begin
        if (out_free) begin
          bin_number     <= rd_bin;
          real_part      <= have_spectrum ? w_rdata[2*WORK_W-1:WORK_W] : '0;
          imag_part      <= have_spectrum ? w_rdata[WORK_W-1:0] : '0;
          spectrum_valid <= have_spectrum;
        end
      end
      default: ;
    endcase
  end

endmodule

@@ rtl/radix2_fft_frame.sv @@
// Channel  Handshake             Payload
// in       in_valid / in_ready   req_type, sample, bin_index
// out      out_valid / out_ready bin_number, real_part, imag_part, spectrum_valid
//
// A push is taken in the engine's idle state; a read passes to the read-out state and waits there on out.
// The push that completes a frame starts a bit-reversed load of the frame, then
// (FRAME_LENGTH/2)*log2(FRAME_LENGTH) butterflies, each read, multiplied and written
// back in turn through the one read port of the work memory and the shared multiplier.
// A two-entry queue holds items while the engine is busy or the result is stalled.
// Reset is synchronous and clears control state; the memories are not cleared.
module radix2_fft_frame
  import rfft_pkg::*;
#(
  parameter int FRAME_LENGTH = 128,
  parameter int TWIDDLE_BITS = 16
) (
  input  logic                       clk,
  input  logic                       rst,
  input  logic                       in_valid,
  output logic                       in_ready,
  input  logic                       req_type,
  input  logic signed [SAMPLE_W-1:0] sample,
  input  logic [BIN_W-1:0]           bin_index,
  output logic                       out_valid,
  input  logic                       out_ready,
  output logic [BIN_W-1:0]           bin_number,
  output logic signed [WORK_W-1:0]   real_part,
  output logic signed [WORK_W-1:0]   imag_part,
  output logic                       spectrum_valid
);

  item_t in_item;
  item_t q_item;
  logic  q_valid;
  logic  q_take;

  assign in_item = '{req_type: req_type, sample: sample, bin_index: bin_index};

  rfft_front u_front (
    .clk      (clk),
    .rst      (rst),
    .in_valid (in_valid),
    .in_ready (in_ready),
    .in_item  (in_item),
    .q_valid  (q_valid),
    .q_take   (q_take),
    .q_item   (q_item)
  );

  rfft_engine #(
    .FRAME_LENGTH (FRAME_LENGTH),
    .TWIDDLE_BITS (TWIDDLE_BITS)
  ) u_engine (
    .clk            (clk),
    .rst            (rst),
    .q_valid        (q_valid),
    .q_take         (q_take),
    .q_item         (q_item),
    .out_valid      (out_valid),
    .out_ready      (out_ready),
    .bin_number     (bin_number),
    .real_part      (real_part),
    .imag_part      (imag_part),
    .spectrum_valid (spectrum_valid)
  );

  a_zero_without_spectrum: assert property (@(posedge clk) disable iff (rst)
    out_valid && !spectrum_valid |-> real_part == '0 && imag_part == '0)
    else $error("bin data nonzero before any transform");

  a_out_clear_after_reset: assert property (@(posedge clk)
    $past(rst) |-> !out_valid)
    else $error("result presented right after reset");

  a_valid_stays_once_set: assert property (@(posedge clk) disable iff (rst)
    $past(spectrum_valid) && out_valid && $past(out_valid && out_ready) |-> spectrum_valid)
    else $error("spectrum flag dropped after a transform");

endmodule

@@ tb/sv/tb.sv @@
`timescale 1ns / 1ps

import rfft_pkg::*;

typedef struct {
  logic [BIN_W-1:0]         bin_number;
  logic signed [WORK_W-1:0] real_part;
  logic signed [WORK_W-1:0] imag_part;
  logic                     spectrum_valid;
} bin_result_t;

class fft_scoreboard;
  localparam int N = 128;
  localparam int TW_BITS = 16;
  localparam longint unsigned TWO_PI_Q51 = 64'h3243F6A8885A31;

  logic signed [SAMPLE_W-1:0] frame_buf[N];
  logic signed [WORK_W-1:0] spec_re[N];
  logic signed [WORK_W-1:0] spec_im[N];
  longint tw_re[N/2];
  longint tw_im[N/2];
  int fill;
  bit have_spec;
  bin_result_t pending_bins[$];
  int errors;

  function new();
    fill = 0;
    have_spec = 0;
    errors = 0;
    build_twiddles();
  endfunction

  // Taylor series in Q31 for an angle in [0, pi/2]
  function longint trig_q31(longint unsigned x, bit want_sin);
    longint unsigned x2, term, a;
    longint acc;
    x2 = (x * x) >> 31;
    term = want_sin ? x : (64'd1 << 31);
    acc = longint'(term);
    for (int n = 1; n <= 12; n++) begin
      a = want_sin ? 2 * n : 2 * n - 1;
      term = ((term * x2) >> 31) / (a * (a + 1));
      if (n % 2 == 1) acc -= longint'(term);
      else acc += longint'(term);
    end
    if (acc < 0) acc = 0;
    if (acc > (64'sd1 <<< 31)) acc = 64'sd1 <<< 31;
    return acc;
  endfunction

  function void build_twiddles();
    longint unsigned m, x;
    longint c, s;
    bit second;
    for (int k = 0; k < N / 2; k++) begin
      second = 4 * k > N;
      m = second ? N / 2 - k : k;
      x = ((m * TWO_PI_Q51) / N + (64'd1 << 19)) >> 20;
      c = (trig_q31(x, 0) + (64'sd1 <<< (31 - TW_BITS))) >>> (32 - TW_BITS);
      s = (trig_q31(x, 1) + (64'sd1 <<< (31 - TW_BITS))) >>> (32 - TW_BITS);
      if (second) c = -c;
      else if (c > (1 << (TW_BITS - 1)) - 1) c = (1 << (TW_BITS - 1)) - 1;
      tw_re[k] = c;
      tw_im[k] = -s;
    end
  endfunction

  // round half up back to sample LSB
  function longint rnd(longint p);
    return (p + (64'sd1 <<< (TW_BITS - 2))) >>> (TW_BITS - 1);
  endfunction

  function longint clip24(longint v);
    if (v > 8388607) return 8388607;
    if (v < -8388608) return -8388608;
    return v;
  endfunction

  function void transform();
    longint wr, wi, orr, oi, er, ei, tr, ti;
    int r, half, stride, e, o;
    for (int i = 0; i < N; i++) begin
      r = 0;
      for (int b = 0; b < 7; b++) if (i[b]) r |= 1 << (6 - b);
      spec_re[r] = frame_buf[i];
      spec_im[r] = '0;
    end
    for (int len = 2; len <= N; len *= 2) begin
      half = len / 2;
      stride = N / len;
      for (int base = 0; base < N; base += len) begin
        for (int j = 0; j < half; j++) begin
          e = base + j;
          o = e + half;
          wr = tw_re[j * stride];
          wi = tw_im[j * stride];
          orr = spec_re[o];
          oi = spec_im[o];
          er = spec_re[e];
          ei = spec_im[e];
          tr = rnd(wr * orr) - rnd(wi * oi);
          ti = rnd(wr * oi) + rnd(wi * orr);
          spec_re[e] = clip24(er + tr);
          spec_im[e] = clip24(ei + ti);
          spec_re[o] = clip24(er - tr);
          spec_im[o] = clip24(ei - ti);
        end
      end
    end
  endfunction

  function void note_input(logic rq, logic signed [SAMPLE_W-1:0] smp, logic [BIN_W-1:0] bin);
    bin_result_t r;
    if (rq == REQ_PUSH) begin
      frame_buf[fill] = smp;
      fill = (fill + 1) % N;
      if (fill == 0) begin
        transform();
        have_spec = 1;
      end
    end else begin
      r.bin_number = bin;
      r.real_part = have_spec ? spec_re[bin] : '0;
      r.imag_part = have_spec ? spec_im[bin] : '0;
      r.spectrum_valid = have_spec;
      pending_bins.push_back(r);
    end
  endfunction

  function void check_result(bin_result_t got);
    bin_result_t exp_r;
    if (pending_bins.size() == 0) begin
      $error("unexpected result for bin %0d", got.bin_number);
      errors++;
      return;
    end
    exp_r = pending_bins.pop_front();
    if (got.bin_number !== exp_r.bin_number) begin
      $error("bin_number: expected %0d, got %0d", exp_r.bin_number, got.bin_number);
      errors++;
    end
    if (got.real_part !== exp_r.real_part) begin
      $error("real_part: expected %0d, got %0d", exp_r.real_part, got.real_part);
      errors++;
    end
    if (got.imag_part !== exp_r.imag_part) begin
      $error("imag_part: expected %0d, got %0d", exp_r.imag_part, got.imag_part);
      errors++;
    end
    if (got.spectrum_valid !== exp_r.spectrum_valid) begin
      $error("spectrum_valid: expected %0d, got %0d", exp_r.spectrum_valid,
             got.spectrum_valid);
      errors++;
    end
  endfunction
endclass

module tb;
  typedef enum int { PAT_RANDOM, PAT_MAX, PAT_MIN, PAT_ALT, PAT_LOW, PAT_BITS } frame_pat_t;

  logic clk = 0;
  logic rst = 1;
  logic in_valid = 0;
  logic in_ready;
  logic req_type = REQ_PUSH;
  logic signed [SAMPLE_W-1:0] sample = '0;
  logic [BIN_W-1:0] bin_index = '0;
  logic out_valid;
  logic out_ready = 0;
  logic [BIN_W-1:0] bin_number;
  logic signed [WORK_W-1:0] real_part;
  logic signed [WORK_W-1:0] imag_part;
  logic spectrum_valid;

  int in_idle_pct = 13;
  int out_idle_pct = 66;
  int transfers = 0;
  fft_scoreboard sb = new();

  radix2_fft_frame dut (.*);

  always begin
    #5 clk = 1;
    #5 clk = 0;
  end

  always @(posedge clk) begin
    if (rst) out_ready <= 1'b0;
    else out_ready <= $urandom_range(0, 99) >= out_idle_pct;
  end

  always @(posedge clk) begin
    bin_result_t got;
    if (!rst && out_valid && out_ready) begin
      got.bin_number = bin_number;
      got.real_part = real_part;
      got.imag_part = imag_part;
      got.spectrum_valid = spectrum_valid;
      sb.check_result(got);
    end
  end

  task automatic send(logic rq, logic signed [SAMPLE_W-1:0] smp, logic [BIN_W-1:0] bin);
    if ($urandom_range(0, 99) < in_idle_pct) begin
      in_valid <= 1'b0;
      do @(posedge clk); while ($urandom_range(0, 99) < in_idle_pct);
    end
    in_valid <= 1'b1;
    req_type <= rq;
    sample <= smp;
    bin_index <= bin;
    do @(posedge clk); while (!in_ready);
    sb.note_input(rq, smp, bin);
    transfers++;
    // switch idle profile by progress
    if (transfers == 320) begin
      in_idle_pct = 66;
      out_idle_pct = 13;
    end else if (transfers == 640) begin
      in_idle_pct = 0;
      out_idle_pct = 0;
    end
  endtask

  task automatic read_bin(logic [BIN_W-1:0] bin);
    send(REQ_READ, SAMPLE_W'($urandom), bin);
  endtask

  task automatic push_frame(frame_pat_t pat, int read_pct);
    logic signed [SAMPLE_W-1:0] v;
    for (int i = 0; i < 128; i++) begin
      case (pat)
        PAT_MAX: v = 16'sh7FFF;
        PAT_MIN: v = -16'sh8000;
        PAT_ALT: v = i[0] ? -16'sh8000 : 16'sh7FFF;
        PAT_LOW: v = $signed(16'($urandom_range(0, 63))) - 16'sd32;
        PAT_BITS: v = 16'(1 << (i % 16));
        default: v = SAMPLE_W'($urandom);
      endcase
      send(REQ_PUSH, v, BIN_W'($urandom));
      if ($urandom_range(0, 99) < read_pct) read_bin(BIN_W'($urandom));
    end
  endtask

  initial begin
    frame_pat_t pat;
    repeat (4) @(posedge clk);
    rst <= 1'b0;
    // no spectrum yet: reads return zero with the flag low
    read_bin(0);
    read_bin(127);
    read_bin(7'h55);
    push_frame(PAT_MAX, 0);
    read_bin(0);
    read_bin(1);
    read_bin(64);
    read_bin(127);
    push_frame(PAT_ALT, 0);
    read_bin(0);
    read_bin(64);
    read_bin(7'h2A);
    while (transfers < 780) begin
      pat = frame_pat_t'($urandom_range(0, 5));
      push_frame(pat, 15);
      repeat ($urandom_range(2, 6)) read_bin(BIN_W'($urandom));
    end
    push_frame(PAT_MIN, 5);
    read_bin(0);
    read_bin(127);
    in_valid <= 1'b0;
    while (sb.pending_bins.size() != 0) @(posedge clk);
    repeat (50) @(posedge clk);
    if (sb.errors == 0) $display("Simulation PASSED");
    else $display("Simulation FAILED");
    $finish;
  end

  initial begin
    #5ms;
    $display("Simulation FAILED");
    $finish;
  end
endmodule

@@ filelist.f @@
rtl/rfft_pkg.sv
rtl/rfft_ram.sv
rtl/rfft_front.sv
rtl/rfft_engine.sv
rtl/radix2_fft_frame.sv
tb/sv/tb.sv
